@@ rtl/wide_unsigned_integer_alu_assert.svh @@
// assertion macros shared by the checker of the wide unsigned alu
// depends on nothing; expects clk and arst_n in the including scope
`ifndef WIDE_UNSIGNED_INTEGER_ALU_ASSERT_SVH
`define WIDE_UNSIGNED_INTEGER_ALU_ASSERT_SVH

// same-cycle implication
`define WUIA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wuia assertion failed");

// next-cycle implication
`define WUIA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wuia assertion failed");

`endif

@@ rtl/wuia_pkg.sv @@
// shared constants and codes of the wide unsigned alu
// no dependencies
`timescale 1ns / 1ps
package wuia_pkg;
	localparam int NUM_WORDS_DEF = 32;
	localparam int WORD_W = 64;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;

	localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SUB = 3'd1;
	localparam logic [FUNC_W-1:0] FN_MUL = 3'd2;
	localparam logic [FUNC_W-1:0] FN_QUO = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REM = 3'd4;
	localparam logic [FUNC_W-1:0] FN_CMP = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVF = 2'd1;
	localparam logic [STAT_W-1:0] ST_NEG = 2'd2;
	localparam logic [STAT_W-1:0] ST_DIVZ = 2'd3;

	localparam logic [1:0] CMP_LT = 2'd0;
	localparam logic [1:0] CMP_EQ = 2'd1;
	localparam logic [1:0] CMP_GT = 2'd2;
endpackage

@@ rtl/wide_unsigned_integer_alu.sv @@
// wide unsigned alu: NUM_WORDS x 64-bit operands, add/sub/mul/quotient/remainder/compare
// load: one request per cycle; after the last word the input stalls until the final answer is registered
// add/sub/compare: one word pass; multiply: 64*NUM_WORDS passes,
// divide: 64*NUM_WORDS+1 passes, each reading its words in turn through the single memory read port
// result words then leave one at a time (memory read then output register), waiting while the output stalls
// arst_n clears control state only; operand and result memories are not cleared
`timescale 1ns / 1ps
module wide_unsigned_integer_alu #(
	parameter int NUM_WORDS = wuia_pkg::NUM_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [wuia_pkg::FUNC_W-1:0]   func,
	input  logic [wuia_pkg::WORD_W-1:0]   a_word,
	input  logic [wuia_pkg::WORD_W-1:0]   b_word,
	input  logic                          last_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wuia_pkg::WORD_W-1:0]   result_word,
	output logic [wuia_pkg::STAT_W-1:0]   status,
	output logic                          last
);
	import wuia_pkg::*;

	// word address, word count, bit index and pass phase widths
	localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int CW = $clog2(NUM_WORDS + 1);
	localparam int BW = $clog2(NUM_WORDS * WORD_W);
	localparam int PW = $clog2(NUM_WORDS + 2);

	typedef enum logic [2:0] {S_IDLE, S_PASS, S_EM_RD, S_EM_WR, S_SGL} state_t;
	// ascending word pass, multiply bit pass, divide bit pass, final quotient shift
	typedef enum logic [1:0] {M_ASC, M_MUL, M_DIV, M_QFIN} mode_t;

	state_t             state_q;
	mode_t              mode_q;
	logic [FUNC_W-1:0]  op_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      n_q;
	logic               bnz_q;
	logic [PW-1:0]      ph_q;
	logic [BW-1:0]      bit_q;
	logic               first_q;
	logic               cur_q;
	logic               take_q;
	logic               cy_q;
	logic               sc_q;
	logic               qc_q;
	logic               ovf_q;
	logic [1:0]         cmp_q;
	logic [WORD_W-1:0]  bitw_q;
	logic [AW-1:0]      e_q;
	logic               esrc_q;
	logic [WORD_W-1:0]  sgl_val_q;
	logic [STAT_W-1:0]  sgl_st_q;
	logic               ov_q;
	logic [WORD_W-1:0]  ow_q;
	logic [STAT_W-1:0]  os_q;
	logic               ol_q;

	// operand, result and two remainder banks
	logic [WORD_W-1:0] a_mem [NUM_WORDS];
	logic [WORD_W-1:0] b_mem [NUM_WORDS];
	logic [WORD_W-1:0] r_mem [NUM_WORDS];
	logic [WORD_W-1:0] m0_mem [NUM_WORDS];
	logic [WORD_W-1:0] m1_mem [NUM_WORDS];

	logic [WORD_W-1:0] a_rd_q, b_rd_q, r_rd_q, m0_rd_q, m1_rd_q;
	logic              a_z_q, b_z_q;
	logic              vld_s1;
	logic [AW-1:0]     idx_s1;

	logic              in_acc, ld_we, issue, free, pass_end;
	logic [AW-1:0]     idx, ab_ra, r_ra, bit_wa;
	logic [CW-1:0]     n_next;
	logic              bnz_next;
	logic [WORD_W-1:0] a_rd, b_rd, m_rd, r_in, m_in;
	logic              k0, klast, bitv;
	logic [WORD_W:0]   sum65, diff65, msum65, dd65;
	logic [WORD_W-1:0] sh, ds, r_wd;
	logic              r_we, m_we;
	logic [1:0]        cmp_n;
	logic              take;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign ld_we = in_acc && (cnt_q < CW'(NUM_WORDS));
	assign n_next = ld_we ? cnt_q + CW'(1) : cnt_q;
	assign bnz_next = bnz_q || (ld_we && (b_word != '0));
	assign free = !ov_q || !out_stall;

	// pass phase: 0 fetches the bit word, 1..N issue word reads, N+1 closes the pass
	assign issue = (state_q == S_PASS) && (ph_q >= PW'(1)) && (ph_q <= PW'(NUM_WORDS));
	assign idx = AW'(ph_q - PW'(1));
	assign pass_end = (state_q == S_PASS) && (ph_q == PW'(NUM_WORDS + 1));
	assign bit_wa = bit_q[BW-1:6];
	assign ab_ra = (state_q == S_PASS && ph_q == '0) ? bit_wa : idx;
	assign r_ra = (state_q == S_EM_RD) ? e_q : idx;

	// memories
	always_ff @(posedge clk) begin
		if (ld_we) begin
			a_mem[cnt_q[AW-1:0]] <= a_word;
			b_mem[cnt_q[AW-1:0]] <= b_word;
		end
		a_rd_q <= a_mem[ab_ra];
		b_rd_q <= b_mem[ab_ra];
		a_z_q <= (CW'(ab_ra) >= n_q);
		b_z_q <= (CW'(ab_ra) >= n_q);
	end

	always_ff @(posedge clk) begin
		if (r_we) begin
			r_mem[idx_s1] <= r_wd;
		end
		r_rd_q <= r_mem[r_ra];
	end

	always_ff @(posedge clk) begin
		if (m_we) begin
			m0_mem[idx_s1] <= cur_q ? dd65[WORD_W-1:0] : ds;
			m1_mem[idx_s1] <= cur_q ? ds : dd65[WORD_W-1:0];
		end
		m0_rd_q <= m0_mem[r_ra];
		m1_rd_q <= m1_mem[r_ra];
	end

	// word datapath
	always_comb begin
		a_rd = a_z_q ? '0 : a_rd_q;
		b_rd = b_z_q ? '0 : b_rd_q;
		m_rd = cur_q ? m1_rd_q : m0_rd_q;
		r_in = first_q ? '0 : r_rd_q;
		m_in = first_q ? '0 : m_rd;
		k0 = (idx_s1 == '0);
		klast = (idx_s1 == AW'(NUM_WORDS - 1));
		bitv = bitw_q[bit_q[5:0]];
		sum65 = {1'b0, a_rd} + {1'b0, b_rd} + {{WORD_W{1'b0}}, cy_q};
		diff65 = {1'b0, a_rd} - {1'b0, b_rd} - {{WORD_W{1'b0}}, cy_q};
		sh = {r_in[WORD_W-2:0], sc_q};
		msum65 = {1'b0, sh} + {1'b0, (bitv ? a_rd : '0)} + {{WORD_W{1'b0}}, cy_q};
		ds = {m_in[WORD_W-2:0], (k0 ? bitv : sc_q)};
		dd65 = {1'b0, ds} - {1'b0, b_rd} - {{WORD_W{1'b0}}, cy_q};
		take = m_in[WORD_W-1] || !dd65[WORD_W];
		cmp_n = cmp_q;
		if (a_rd != b_rd) begin
			cmp_n = (a_rd < b_rd) ? CMP_LT : CMP_GT;
		end
		r_we = 1'b0;
		m_we = 1'b0;
		r_wd = '0;
		case (mode_q)
			M_ASC: begin
				r_we = vld_s1;
				r_wd = (op_q == FN_ADD) ? sum65[WORD_W-1:0] : diff65[WORD_W-1:0];
			end
			M_MUL: begin
				r_we = vld_s1;
				r_wd = msum65[WORD_W-1:0];
			end
			M_DIV: begin
				r_we = vld_s1;
				m_we = vld_s1;
				r_wd = {r_in[WORD_W-2:0], (k0 ? take_q : qc_q)};
			end
			M_QFIN: begin
				r_we = vld_s1;
				r_wd = {r_in[WORD_W-2:0], (k0 ? take_q : qc_q)};
			end
			default: begin
				r_we = 1'b0;
			end
		endcase
	end

	// control, carries and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= M_ASC;
			op_q <= FN_ADD;
			cnt_q <= '0;
			n_q <= '0;
			bnz_q <= 1'b0;
			ph_q <= '0;
			bit_q <= '0;
			first_q <= 1'b0;
			cur_q <= 1'b0;
			take_q <= 1'b0;
			cy_q <= 1'b0;
			sc_q <= 1'b0;
			qc_q <= 1'b0;
			ovf_q <= 1'b0;
			cmp_q <= CMP_EQ;
			bitw_q <= '0;
			e_q <= '0;
			esrc_q <= 1'b0;
			sgl_val_q <= '0;
			sgl_st_q <= ST_OK;
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
			ov_q <= 1'b0;
			ow_q <= '0;
			os_q <= ST_OK;
			ol_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			idx_s1 <= idx;
			// the loading states set the flag themselves
			if (ov_q && !out_stall && state_q != S_SGL && state_q != S_EM_WR) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (last_word) begin
							cnt_q <= '0;
							n_q <= n_next;
							bnz_q <= 1'b0;
							op_q <= func;
							ph_q <= '0;
							bit_q <= BW'(NUM_WORDS * WORD_W - 1);
							first_q <= 1'b1;
							cur_q <= 1'b0;
							take_q <= 1'b0;
							ovf_q <= 1'b0;
							cmp_q <= CMP_EQ;
							e_q <= '0;
							esrc_q <= 1'b0;
							case (func)
								FN_ADD, FN_SUB, FN_CMP: begin
									mode_q <= M_ASC;
									state_q <= S_PASS;
								end
								FN_MUL: begin
									mode_q <= M_MUL;
									state_q <= S_PASS;
								end
								FN_QUO, FN_REM: begin
									mode_q <= M_DIV;
									if (bnz_next) begin
										state_q <= S_PASS;
									end else begin
										sgl_val_q <= '0;
										sgl_st_q <= ST_DIVZ;
										state_q <= S_SGL;
									end
								end
								default: begin
									sgl_val_q <= '0;
									sgl_st_q <= ST_OK;
									state_q <= S_SGL;
								end
							endcase
						end else begin
							cnt_q <= n_next;
							bnz_q <= bnz_next;
						end
					end
				end
				S_PASS: begin
					ph_q <= pass_end ? '0 : ph_q + PW'(1);
					if (ph_q == '0) begin
						cy_q <= 1'b0;
						sc_q <= 1'b0;
						qc_q <= 1'b0;
					end
					if (ph_q == PW'(1)) begin
						bitw_q <= (mode_q == M_DIV) ? a_rd : b_rd;
					end
					// per-word carries
					if (vld_s1) begin
						case (mode_q)
							M_ASC: begin
								cy_q <= (op_q == FN_ADD) ? sum65[WORD_W] : diff65[WORD_W];
								cmp_q <= cmp_n;
							end
							M_MUL: begin
								cy_q <= msum65[WORD_W];
								sc_q <= r_in[WORD_W-1];
								if (klast) begin
									ovf_q <= ovf_q || r_in[WORD_W-1] || msum65[WORD_W];
								end
							end
							M_DIV: begin
								cy_q <= dd65[WORD_W];
								sc_q <= m_in[WORD_W-1];
								qc_q <= r_in[WORD_W-1];
							end
							M_QFIN: begin
								qc_q <= r_in[WORD_W-1];
							end
							default: begin
								cy_q <= cy_q;
							end
						endcase
					end
					// the top word is handled in this same cycle
					if (pass_end) begin
						case (mode_q)
							M_ASC: begin
								if (op_q == FN_CMP) begin
									sgl_val_q <= WORD_W'(cmp_n);
									sgl_st_q <= ST_OK;
									state_q <= S_SGL;
								end else if ((op_q == FN_ADD) ? sum65[WORD_W] :
										diff65[WORD_W]) begin
									sgl_val_q <= '0;
									sgl_st_q <= (op_q == FN_ADD) ? ST_OVF : ST_NEG;
									state_q <= S_SGL;
								end else begin
									state_q <= S_EM_RD;
								end
							end
							M_MUL: begin
								first_q <= 1'b0;
								bit_q <= bit_q - BW'(1);
								if (bit_q == '0) begin
									if (ovf_q || r_in[WORD_W-1] || msum65[WORD_W]) begin
										sgl_val_q <= '0;
										sgl_st_q <= ST_OVF;
										state_q <= S_SGL;
									end else begin
										state_q <= S_EM_RD;
									end
								end
							end
							M_DIV: begin
								first_q <= 1'b0;
								// take decided on the top word in the last cycle
								take_q <= take;
								cur_q <= cur_q ^ take;
								bit_q <= bit_q - BW'(1);
								if (bit_q == '0) begin
									mode_q <= M_QFIN;
								end
							end
							M_QFIN: begin
								esrc_q <= (op_q == FN_REM);
								state_q <= S_EM_RD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_EM_RD: begin
					if (free) begin
						state_q <= S_EM_WR;
					end
				end
				S_EM_WR: begin
					ov_q <= 1'b1;
					ow_q <= esrc_q ? m_rd : r_rd_q;
					os_q <= ST_OK;
					ol_q <= (e_q == AW'(NUM_WORDS - 1));
					e_q <= e_q + AW'(1);
					state_q <= (e_q == AW'(NUM_WORDS - 1)) ? S_IDLE : S_EM_RD;
				end
				S_SGL: begin
					if (free) begin
						ov_q <= 1'b1;
						ow_q <= sgl_val_q;
						os_q <= sgl_st_q;
						ol_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = ov_q;
	assign result_word = ow_q;
	assign status = os_q;
	assign last = ol_q;
endmodule

@@ rtl/wuia_chk.sv @@
// port-level checker for the wide unsigned alu, bound to the top level
// depends on wuia_pkg and wide_unsigned_integer_alu_assert.svh
`timescale 1ns / 1ps
`include "wide_unsigned_integer_alu_assert.svh"
module wuia_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        last_word,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [wuia_pkg::WORD_W-1:0] result_word,
	input logic [wuia_pkg::STAT_W-1:0] status,
	input logic                        last
);
	import wuia_pkg::*;

	// an error result is always a lone final item with zero data
	`WUIA_ASSERT_NOW(a_err_last, out_valid && status != ST_OK, last)
	`WUIA_ASSERT_NOW(a_err_zero, out_valid && status != ST_OK, result_word == '0)
	// closing word of an operand blocks further input while work runs
	`WUIA_ASSERT_NEXT(a_busy, in_valid && !in_stall && last_word, in_stall)
	// held result request stays put
	`WUIA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(result_word))
endmodule

bind wide_unsigned_integer_alu wuia_chk u_wuia_chk (.*);

@@ tb/tb_wide_unsigned_integer_alu.sv @@
// testbench of the wide unsigned alu: directed and random operations on 2048-bit operands
// depends on wuia_pkg and wide_unsigned_integer_alu; predicts results with wide vector arithmetic
`timescale 1ns / 1ps
module tb_wide_unsigned_integer_alu;
	import wuia_pkg::*;

	localparam int NW = NUM_WORDS_DEF;
	localparam int BITS = NW * WORD_W;

	// one request word as offered to the block
	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic              last_word;
		bit                wait_idle;
	} word_req_t;

	// one result item of the block
	typedef struct {
		logic [WORD_W-1:0] word;
		logic [STAT_W-1:0] status;
		logic              last;
	} alu_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [WORD_W-1:0] a_word = '0;
	logic [WORD_W-1:0] b_word = '0;
	logic last_word = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [WORD_W-1:0] result_word;
	logic [STAT_W-1:0] status;
	logic last;

	word_req_t pending_words[$];
	alu_res_t  expected_results[$];

	// predictor state: operands gathered so far and the word position
	logic [BITS-1:0] acc_a = '0;
	logic [BITS-1:0] acc_b = '0;
	int unsigned     words_loaded = 0;

	int unsigned mismatches = 0;
	bit          idle_on = 1'b1;
	bit          hold_trig = 1'b0;
	bit          hold_seen = 1'b0;
	int unsigned hold_left = 0;
	logic        rx_hold = 1'b0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned items_queued = 0;
	int unsigned slow_left;

	always #5 clk = ~clk;

	wide_unsigned_integer_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.a_word(a_word),
		.b_word(b_word),
		.last_word(last_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_word(result_word),
		.status(status),
		.last(last)
	);

	function automatic void expect_single(logic [WORD_W-1:0] value, logic [STAT_W-1:0] st);
		alu_res_t r;
		r.word = value;
		r.status = st;
		r.last = 1'b1;
		expected_results.push_back(r);
	endfunction

	function automatic void expect_words(logic [BITS-1:0] value);
		alu_res_t r;
		for (int k = 0; k < NW; k++) begin
			r.word = value[k*WORD_W +: WORD_W];
			r.status = ST_OK;
			r.last = (k == NW - 1);
			expected_results.push_back(r);
		end
	endfunction

	// gathers one accepted request word; on the last word works out the answer
	function automatic void alu_take_word(word_req_t w);
		logic [BITS:0]     sum;
		logic [2*BITS-1:0] prod;
		if (words_loaded < NW) begin
			acc_a[words_loaded*WORD_W +: WORD_W] = w.a;
			acc_b[words_loaded*WORD_W +: WORD_W] = w.b;
			words_loaded++;
		end
		if (!w.last_word)
			return;
		// words never loaded in this operation count as zero
		for (int k = words_loaded; k < NW; k++) begin
			acc_a[k*WORD_W +: WORD_W] = '0;
			acc_b[k*WORD_W +: WORD_W] = '0;
		end
		words_loaded = 0;
		case (w.func)
			FN_ADD: begin
				sum = {1'b0, acc_a} + {1'b0, acc_b};
				if (sum[BITS])
					expect_single('0, ST_OVF);
				else
					expect_words(sum[BITS-1:0]);
			end
			FN_SUB: begin
				if (acc_a < acc_b)
					expect_single('0, ST_NEG);
				else
					expect_words(acc_a - acc_b);
			end
			FN_MUL: begin
				prod = {{BITS{1'b0}}, acc_a} * {{BITS{1'b0}}, acc_b};
				if (prod[2*BITS-1:BITS] != '0)
					expect_single('0, ST_OVF);
				else
					expect_words(prod[BITS-1:0]);
			end
			FN_QUO: begin
				if (acc_b == '0)
					expect_single('0, ST_DIVZ);
				else
					expect_words(acc_a / acc_b);
			end
			FN_REM: begin
				if (acc_b == '0)
					expect_single('0, ST_DIVZ);
				else
					expect_words(acc_a % acc_b);
			end
			FN_CMP: begin
				if (acc_a < acc_b)
					expect_single({{(WORD_W-2){1'b0}}, CMP_LT}, ST_OK);
				else if (acc_a == acc_b)
					expect_single({{(WORD_W-2){1'b0}}, CMP_EQ}, ST_OK);
				else
					expect_single({{(WORD_W-2){1'b0}}, CMP_GT}, ST_OK);
			end
			// unused codes answer with one plain item
			default: expect_single('0, ST_OK);
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// random operand of n words, the rest zero
	function automatic logic [BITS-1:0] rand_operand(int unsigned n);
		logic [BITS-1:0] v;
		v = '0;
		for (int k = 0; k < NW; k++)
			if (k < n)
				v[k*WORD_W +: WORD_W] = rand_word();
		return v;
	endfunction

	// splits one operation into request words; words past NW carry noise and are dropped
	task automatic queue_op(input logic [FUNC_W-1:0] fn, input logic [BITS-1:0] opa,
			input logic [BITS-1:0] opb, input int unsigned n, input bit wait_idle);
		word_req_t w;
		for (int k = 0; k < n; k++) begin
			w.func = (k == n - 1) ? fn : FUNC_W'($urandom);
			w.a = (k < NW) ? opa[k*WORD_W +: WORD_W] : rand_word();
			w.b = (k < NW) ? opb[k*WORD_W +: WORD_W] : rand_word();
			w.last_word = (k == n - 1);
			w.wait_idle = wait_idle && (k == 0);
			pending_words.push_back(w);
		end
		items_queued += n;
	endtask

	// one random operation; multiply and divide are rationed since each runs one pass per operand bit
	task automatic queue_random_op();
		logic [FUNC_W-1:0] fn;
		logic [BITS-1:0]   opa, opb, t;
		int unsigned       n;
		int unsigned       pick;
		pick = $urandom_range(0, 15);
		if (pick < 2)
			n = NW;
		else if (pick == 2)
			n = NW + $urandom_range(1, 3);
		else
			n = $urandom_range(1, 4);
		if (slow_left > 0 && $urandom_range(0, 4) == 0) begin
			slow_left--;
			case ($urandom_range(0, 2))
				0: fn = FN_MUL;
				1: fn = FN_QUO;
				default: fn = FN_REM;
			endcase
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: fn = FN_ADD;
				3, 4, 5: fn = FN_SUB;
				6, 7, 8: fn = FN_CMP;
				default: fn = FUNC_W'($urandom_range(6, 7));
			endcase
		end
		opa = rand_operand(n);
		opb = rand_operand((fn == FN_MUL || fn == FN_QUO || fn == FN_REM) ?
			$urandom_range(1, n) : n);
		// keep most differences non-negative and let some compares be equal
		if (fn == FN_SUB && $urandom_range(0, 3) != 0 && opa < opb) begin
			t = opa;
			opa = opb;
			opb = t;
		end
		if (fn == FN_CMP && $urandom_range(0, 3) == 0)
			opb = opa;
		if ((fn == FN_QUO || fn == FN_REM) && $urandom_range(0, 7) == 0)
			opb = '0;
		queue_op(fn, opa, opb, n, 1'b0);
	endtask

	// driver: offers queued request words and feeds accepted ones to the predictor
	always @(posedge clk or negedge arst_n) begin
		word_req_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				w.func = func;
				w.a = a_word;
				w.b = b_word;
				w.last_word = last_word;
				w.wait_idle = 1'b0;
				alu_take_word(w);
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_words[0].wait_idle && expected_results.size() != 0) begin
					// sender pause: nothing more until every answer is back
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 5) == 0) begin
					tx_gap = $urandom_range(0, 14);
					in_valid <= 1'b0;
				end else begin
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					func <= w.func;
					a_word <= w.a;
					b_word <= w.b;
					last_word <= w.last_word;
				end
			end
		end
	end

	// long receiver hold-off, counted here so the monitor only sees a flag
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold <= 1'b0;
		end else begin
			if (hold_trig != hold_seen) begin
				hold_seen = hold_trig;
				hold_left = 600;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			rx_hold <= (hold_left > 0);
		end
	end

	// monitor: checks each accepted answer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		alu_res_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result word %h status %0d last %0b",
							$realtime, result_word, status, last);
				end else begin
					e = expected_results.pop_front();
					if (result_word !== e.word || status !== e.status || last !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp %h/%0d/%0b got %h/%0d/%0b",
								$realtime, e.word, e.status, e.last,
								result_word, status, last);
					end
				end
			end
			// random stall bursts; none once idling is switched off
			if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= rx_hold;
			end
		end
	end

	initial begin
		logic [BITS-1:0] all_ones;
		logic [BITS-1:0] one;
		all_ones = '1;
		one = BITS'(1);
		slow_left = 5;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: full-width extremes, error paths, unused codes, odd lengths
		queue_op(FN_ADD, all_ones, one, NW, 1'b0);
		queue_op(FN_MUL, all_ones, all_ones, NW + 2, 1'b0);
		queue_op(FN_SUB, '0, one, 1, 1'b0);
		queue_op(FN_SUB, {{(BITS-64){1'b0}}, 64'hffff_ffff_ffff_ffff},
			{{(BITS-64){1'b0}}, 64'hffff_ffff_ffff_ffff}, 1, 1'b0);
		queue_op(FN_MUL, rand_operand(2), rand_operand(2), 2, 1'b0);
		queue_op(FN_QUO, rand_operand(1), '0, 1, 1'b0);
		queue_op(FN_REM, rand_operand(2), '0, 2, 1'b0);
		queue_op(FN_QUO, BITS'(5), BITS'(9), 1, 1'b0);
		queue_op(FN_REM, rand_operand(2), rand_operand(1), 2, 1'b0);
		queue_op(FN_CMP, BITS'(3), BITS'(4), 1, 1'b0);
		queue_op(FN_CMP, BITS'(4), BITS'(4), 1, 1'b0);
		queue_op(FN_CMP, BITS'(5), BITS'(4), 1, 1'b0);
		queue_op(FUNC_W'(6), rand_operand(1), rand_operand(1), 1, 1'b0);
		queue_op(FUNC_W'(7), rand_operand(1), rand_operand(1), 1, 1'b0);

		// sender waits for the block to drain before this one
		queue_op(FN_ADD, rand_operand(2), rand_operand(2), 2, 1'b1);
		wait (pending_words.size() == 0);

		// receiver holds off long while short requests keep coming
		@(negedge clk);
		hold_trig = ~hold_trig;
		for (int k = 0; k < 10; k++)
			queue_op(FN_ADD, rand_operand(2), rand_operand(2), $urandom_range(1, 3), 1'b0);
		wait (pending_words.size() == 0);

		while (items_queued < 130)
			queue_random_op();
		wait (pending_words.size() == 0);

		// last stretch runs back to back
		@(negedge clk);
		idle_on = 1'b0;
		while (items_queued < 155)
			queue_random_op();
		wait (pending_words.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
